[rtl/svpwm_pkg.sv]
// ----------------------------------------------------------------------------
// SVPWM package
// Shared widths and constants for the space vector PWM duty generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int FracBits = 15;
   localparam int OneVal = 1 << FracBits;
   // Round(sqrt(3)/2 * 2^15).
   localparam logic [15:0] KCoef = 16'd28378;
   // One squared at Q30.
   localparam logic [31:0] OneSq = 32'h4000_0000;
   localparam int SqSteps = 17;
   localparam int DivSteps = 18;

endpackage

[rtl/svpwm_divider.sv]
// ----------------------------------------------------------------------------
// SVPWM pipelined divider
// Restoring divider, one quotient bit per stage, unsigned 34 by 17 bits.
// ----------------------------------------------------------------------------
module svpwm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [33:0] in_num,
   input  logic [16:0] in_den,
   input  logic [63:0] in_side,
   output logic        out_valid,
   output logic [17:0] out_quo,
   output logic [63:0] out_side
);

   logic [svpwm_pkg::DivSteps:1] valid_ff;
   logic [17:0]                  rem_ff  [1:svpwm_pkg::DivSteps];
   logic [33:0]                  num_ff  [1:svpwm_pkg::DivSteps];
   logic [16:0]                  den_ff  [1:svpwm_pkg::DivSteps];
   logic [17:0]                  quo_ff  [1:svpwm_pkg::DivSteps];
   logic [63:0]                  side_ff [1:svpwm_pkg::DivSteps];

   for (genvar i = 0; i < svpwm_pkg::DivSteps; i++) begin : g_stage
      logic        valid_cur;
      logic [33:0] num_cur;
      logic [16:0] den_cur;
      logic [17:0] quo_cur;
      logic [63:0] side_cur;
      logic [34:0] trial;
      if (i == 0) begin : g_first
         // Quotient fits in 18 bits, so the top numerator bits start the remainder.
         assign valid_cur = in_valid;
         assign num_cur   = in_num;
         assign den_cur   = in_den;
         assign quo_cur   = 18'd0;
         assign side_cur  = in_side;
         assign trial     = {18'd0, in_num[33:17]};
      end else begin : g_next
         assign valid_cur = valid_ff[i];
         assign num_cur   = num_ff[i];
         assign den_cur   = den_ff[i];
         assign quo_cur   = quo_ff[i];
         assign side_cur  = side_ff[i];
         assign trial     = {16'd0, rem_ff[i], num_ff[i][17-i]};
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else valid_ff[i+1] <= valid_cur;
         num_ff[i+1]  <= num_cur;
         den_ff[i+1]  <= den_cur;
         side_ff[i+1] <= side_cur;
         if (trial >= {18'd0, den_cur}) begin
            rem_ff[i+1] <= 18'(trial - {18'd0, den_cur});
            quo_ff[i+1] <= {quo_cur[16:0], 1'b1};
         end else begin
            rem_ff[i+1] <= trial[17:0];
            quo_ff[i+1] <= {quo_cur[16:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[svpwm_pkg::DivSteps];
   assign out_quo   = quo_ff[svpwm_pkg::DivSteps];
   assign out_side  = side_ff[svpwm_pkg::DivSteps];

endmodule

[rtl/svpwm_duty_generator.sv]
// ----------------------------------------------------------------------------
// SVPWM duty generator
// Seven-segment space vector PWM: limit, inverse Park, sector, duty times.
// ----------------------------------------------------------------------------
// Pipeline from the accepting edge to rsp_valid: two input stages,
// a 17-stage square root, an 18-stage reciprocal divider, seven scaling and
// sector stages, the 18-stage ratio dividers and two output stages.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset: synchronous; clears all valid bits, payload registers are not reset.
module svpwm_duty_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_d_voltage,
   input  logic signed [15:0] req_q_voltage,
   input  logic signed [15:0] req_angle_sine,
   input  logic signed [15:0] req_angle_cosine,
   output logic               rsp_valid,
   output logic [15:0]        rsp_duty_u,
   output logic [15:0]        rsp_duty_v,
   output logic [15:0]        rsp_duty_w,
   output logic [2:0]         rsp_sector_code
);

   assign busy = 1'b0;

   // Stage A: squares.
   logic               a_valid_ff;
   logic signed [15:0] a_d_ff, a_q_ff, a_s_ff, a_c_ff;
   logic [31:0]        a_dd_ff, a_qq_ff;
   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else a_valid_ff <= start;
      a_d_ff  <= req_d_voltage;
      a_q_ff  <= req_q_voltage;
      a_s_ff  <= req_angle_sine;
      a_c_ff  <= req_angle_cosine;
      a_dd_ff <= 32'(req_d_voltage * req_d_voltage);
      a_qq_ff <= 32'(req_q_voltage * req_q_voltage);
   end

   // Stage B: magnitude and limit flag.
   logic               b_valid_ff, b_lim_ff;
   logic signed [15:0] b_d_ff, b_q_ff, b_s_ff, b_c_ff;
   logic [32:0]        b_m_ff;
   always_ff @(posedge clock) begin
      logic [32:0] m_in;
      m_in = {1'b0, a_dd_ff} + {1'b0, a_qq_ff};
      if (reset) b_valid_ff <= 1'b0;
      else b_valid_ff <= a_valid_ff;
      b_m_ff   <= m_in;
      b_lim_ff <= m_in > {1'b0, svpwm_pkg::OneSq};
      b_d_ff <= a_d_ff; b_q_ff <= a_q_ff; b_s_ff <= a_s_ff; b_c_ff <= a_c_ff;
   end

   // Square root: one result bit per stage (m is at most 2^31, so the root stays
   // below 2^16).
   logic [svpwm_pkg::SqSteps:1] sq_valid_ff;
   logic [33:0]                 sq_v_ff   [1:svpwm_pkg::SqSteps];
   logic [33:0]                 sq_res_ff [1:svpwm_pkg::SqSteps];
   logic [64:0]                 sq_side_ff[1:svpwm_pkg::SqSteps];
   for (genvar i = 0; i < svpwm_pkg::SqSteps; i++) begin : g_sq
      localparam logic [33:0] Bit = 34'd1 << (2 * (svpwm_pkg::SqSteps - 1 - i));
      logic        valid_cur;
      logic [33:0] v_cur, res_cur;
      logic [64:0] side_cur;
      if (i == 0) begin : g_first
         assign valid_cur = b_valid_ff;
         assign v_cur     = {1'b0, b_m_ff};
         assign res_cur   = 34'd0;
         assign side_cur  = {b_lim_ff, b_d_ff, b_q_ff, b_s_ff, b_c_ff};
      end else begin : g_next
         assign valid_cur = sq_valid_ff[i];
         assign v_cur     = sq_v_ff[i];
         assign res_cur   = sq_res_ff[i];
         assign side_cur  = sq_side_ff[i];
      end
      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[i+1] <= 1'b0;
         else sq_valid_ff[i+1] <= valid_cur;
         sq_side_ff[i+1] <= side_cur;
         if (v_cur >= res_cur + Bit) begin
            sq_v_ff[i+1]   <= v_cur - (res_cur + Bit);
            sq_res_ff[i+1] <= (res_cur >> 1) + Bit;
         end else begin
            sq_v_ff[i+1]   <= v_cur;
            sq_res_ff[i+1] <= res_cur >> 1;
         end
      end
   end

   // Reciprocal 2^30 / r.
   logic        rc_valid;
   logic [17:0] rc_quo;
   logic [63:0] rc_side;
   logic        rc_lim_ff;
   logic        rc_lim;
   logic [16:0] root;
   assign root = (sq_res_ff[svpwm_pkg::SqSteps][16:0] == 17'd0) ? 17'd1 :
                 sq_res_ff[svpwm_pkg::SqSteps][16:0];
   svpwm_divider u_recip (
      .clock(clock), .reset(reset), .in_valid(sq_valid_ff[svpwm_pkg::SqSteps]),
      .in_num({2'd0, svpwm_pkg::OneSq}), .in_den(root),
      .in_side(sq_side_ff[svpwm_pkg::SqSteps][63:0]),
      .out_valid(rc_valid), .out_quo(rc_quo), .out_side(rc_side)
   );
   // Limit flag follows the divider through its own delay line.
   logic [17:0] lim_line_ff;
   always_ff @(posedge clock) begin
      lim_line_ff <= {lim_line_ff[16:0], sq_side_ff[svpwm_pkg::SqSteps][64]};
   end
   assign rc_lim = lim_line_ff[17];
   assign rc_lim_ff = rc_lim;

   // Stage C: scale d and q.
   logic               c_valid_ff;
   logic signed [35:0] c_dp_ff, c_qp_ff;
   logic signed [15:0] c_s_ff, c_c_ff, c_d_ff, c_q_ff;
   logic               c_lim_ff;
   always_ff @(posedge clock) begin
      logic signed [18:0] rcs;
      rcs = $signed({1'b0, rc_quo});
      if (reset) c_valid_ff <= 1'b0;
      else c_valid_ff <= rc_valid;
      c_dp_ff <= 36'($signed(rc_side[63:48]) * rcs);
      c_qp_ff <= 36'($signed(rc_side[47:32]) * rcs);
      c_d_ff <= rc_side[63:48]; c_q_ff <= rc_side[47:32];
      c_s_ff <= rc_side[31:16]; c_c_ff <= rc_side[15:0];
      c_lim_ff <= rc_lim_ff;
   end

   // Stage D: choose limited or raw d, q (17 bits signed).
   logic               d_valid_ff;
   logic signed [16:0] d_d_ff, d_q_ff;
   logic signed [15:0] d_s_ff, d_c_ff;
   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else d_valid_ff <= c_valid_ff;
      d_d_ff <= c_lim_ff ? 17'(c_dp_ff >>> svpwm_pkg::FracBits) : 17'(c_d_ff);
      d_q_ff <= c_lim_ff ? 17'(c_qp_ff >>> svpwm_pkg::FracBits) : 17'(c_q_ff);
      d_s_ff <= c_s_ff; d_c_ff <= c_c_ff;
   end

   // Stage E: inverse Park products.
   logic               e_valid_ff;
   logic signed [33:0] e_dc_ff, e_qs_ff, e_qc_ff, e_ds_ff;
   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else e_valid_ff <= d_valid_ff;
      e_dc_ff <= 34'(d_d_ff * d_c_ff);
      e_qs_ff <= 34'(d_q_ff * d_s_ff);
      e_qc_ff <= 34'(d_q_ff * d_c_ff);
      e_ds_ff <= 34'(d_d_ff * d_s_ff);
   end

   // Stage F: alpha and beta.
   logic               f_valid_ff;
   logic signed [19:0] f_alpha_ff, f_beta_ff;
   always_ff @(posedge clock) begin
      logic signed [34:0] a_sum, b_sum;
      a_sum = 35'(e_dc_ff) - 35'(e_qs_ff);
      b_sum = 35'(e_qc_ff) + 35'(e_ds_ff);
      if (reset) f_valid_ff <= 1'b0;
      else f_valid_ff <= e_valid_ff;
      f_alpha_ff <= 20'(a_sum >>> svpwm_pkg::FracBits);
      f_beta_ff  <= 20'(b_sum >>> svpwm_pkg::FracBits);
   end

   // Stage G: k * alpha.
   logic               g_valid_ff;
   logic signed [36:0] g_ka_ff;
   logic signed [19:0] g_beta_ff;
   always_ff @(posedge clock) begin
      if (reset) g_valid_ff <= 1'b0;
      else g_valid_ff <= f_valid_ff;
      g_ka_ff   <= 37'(f_alpha_ff * $signed({1'b0, svpwm_pkg::KCoef}));
      g_beta_ff <= f_beta_ff;
   end

   // Stage H: comparison voltages, sector, x and y.
   logic               h_valid_ff;
   logic [2:0]         h_sec_ff;
   logic signed [21:0] h_x_ff, h_y_ff;
   always_ff @(posedge clock) begin
      logic signed [21:0] ka, hb, u1, u2, u3, xs, ys;
      logic [2:0] sec;
      ka = 22'(g_ka_ff >>> svpwm_pkg::FracBits);
      hb = 22'(g_beta_ff >>> 1);
      u1 = 22'(g_beta_ff);
      u2 = -ka - hb;
      u3 = ka - hb;
      sec = {u3 > 0, u2 > 0, u1 > 0};
      case (sec)
         3'd5: begin xs = u3;  ys = u1;  end
         3'd1: begin xs = -u3; ys = -u2; end
         3'd3: begin xs = u1;  ys = u2;  end
         3'd2: begin xs = -u1; ys = -u3; end
         3'd6: begin xs = u2;  ys = u3;  end
         3'd4: begin xs = -u2; ys = -u1; end
         default: begin xs = '0; ys = '0; end
      endcase
      if (reset) h_valid_ff <= 1'b0;
      else h_valid_ff <= g_valid_ff;
      h_sec_ff <= sec;
      h_x_ff <= xs;
      h_y_ff <= ys;
   end

   // Stage I: sum, over-modulation flag.
   logic               i_valid_ff, i_over_ff;
   logic [2:0]         i_sec_ff;
   logic signed [21:0] i_x_ff, i_y_ff;
   logic [16:0]        i_sum_ff;
   always_ff @(posedge clock) begin
      logic signed [22:0] sm;
      sm = 23'(h_x_ff) + 23'(h_y_ff);
      if (reset) i_valid_ff <= 1'b0;
      else i_valid_ff <= h_valid_ff;
      i_over_ff <= sm > 23'(svpwm_pkg::OneVal);
      i_sum_ff  <= 17'(sm);
      i_sec_ff <= h_sec_ff; i_x_ff <= h_x_ff; i_y_ff <= h_y_ff;
   end

   // Ratio dividers; both times are positive when scaling applies.
   logic        dx_valid, dy_valid;
   logic [17:0] dx_quo, dy_quo;
   logic [63:0] dx_side, dy_side;
   logic [16:0] xa, ya;
   assign xa = i_x_ff[16:0];
   assign ya = i_y_ff[16:0];
   svpwm_divider u_div_x (
      .clock(clock), .reset(reset), .in_valid(i_valid_ff),
      .in_num({2'd0, xa, 15'd0}), .in_den(i_over_ff ? i_sum_ff : 17'd1),
      .in_side({i_valid_ff, i_over_ff, i_sec_ff, 15'd0, i_x_ff, i_y_ff}),
      .out_valid(dx_valid), .out_quo(dx_quo), .out_side(dx_side)
   );
   svpwm_divider u_div_y (
      .clock(clock), .reset(reset), .in_valid(i_valid_ff),
      .in_num({2'd0, ya, 15'd0}), .in_den(i_over_ff ? i_sum_ff : 17'd1),
      .in_side(64'd0),
      .out_valid(dy_valid), .out_quo(dy_quo), .out_side(dy_side)
   );

   // Stage J: final times.
   logic               j_valid_ff;
   logic [2:0]         j_sec_ff;
   logic signed [22:0] j_x_ff, j_y_ff;
   always_ff @(posedge clock) begin
      logic ov;
      ov = dx_side[62];
      if (reset) j_valid_ff <= 1'b0;
      else j_valid_ff <= dx_valid & dy_valid;
      j_sec_ff <= dx_side[61:59];
      j_x_ff <= ov ? 23'($signed({1'b0, dx_quo})) : 23'($signed(dx_side[43:22]));
      j_y_ff <= ov ? 23'($signed({1'b0, dy_quo})) : 23'($signed(dx_side[21:0]));
   end
   logic unused_side;
   assign unused_side = ^{dy_side, dx_side[63], dx_side[58:44]};

   function automatic logic [15:0] clampq(input logic signed [23:0] t);
      if (t < 0) return 16'd0;
      if (t > 24'(svpwm_pkg::OneVal)) return 16'(svpwm_pkg::OneVal);
      return t[15:0];
   endfunction

   // Stage K: duties.
   always_ff @(posedge clock) begin
      logic signed [23:0] t7, ta, tb, tc, xy;
      xy = 24'(j_x_ff) + 24'(j_y_ff);
      t7 = (24'(svpwm_pkg::OneVal) - xy) >>> 1;
      case (j_sec_ff)
         3'd5: begin ta = xy + t7; tb = 24'(j_y_ff) + t7; tc = t7; end
         3'd1: begin ta = 24'(j_y_ff) + t7; tb = xy + t7; tc = t7; end
         3'd3: begin ta = t7; tb = xy + t7; tc = 24'(j_y_ff) + t7; end
         3'd2: begin ta = t7; tb = 24'(j_y_ff) + t7; tc = xy + t7; end
         3'd6: begin ta = 24'(j_y_ff) + t7; tb = t7; tc = xy + t7; end
         3'd4: begin ta = xy + t7; tb = t7; tc = 24'(j_y_ff) + t7; end
         default: begin
            ta = 24'(svpwm_pkg::OneVal / 2);
            tb = ta; tc = ta;
         end
      endcase
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= j_valid_ff;
      rsp_duty_u <= clampq(ta);
      rsp_duty_v <= clampq(tb);
      rsp_duty_w <= clampq(tc);
      rsp_sector_code <= j_sec_ff;
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SVPWM duty generator testbench
// Drives d/q commands and angle pairs through the duty generator, predicts
// each item's duties and sector in fixed point, and checks every result in
// order while the sender idles at several rates.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [15:0] duty_u;
      logic [15:0] duty_v;
      logic [15:0] duty_w;
      logic [2:0]  sector;
   } duty_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_d_voltage = '0;
   logic signed [15:0] req_q_voltage = '0;
   logic signed [15:0] req_angle_sine = '0;
   logic signed [15:0] req_angle_cosine = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_duty_u;
   logic [15:0]        rsp_duty_v;
   logic [15:0]        rsp_duty_w;
   logic [2:0]         rsp_sector_code;

   duty_type expected_duties[$];
   int       error_count = 0;
   int       idle_pct = 0;

   svpwm_duty_generator u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("tb_top failed");
      $finish;
   end

   function automatic longint floor_shift(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint sqrt_floor(longint v);
      longint r = 0;
      longint b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] clamp_q15(longint t);
      if (t < 0) t = 0;
      if (t > svpwm_pkg::OneVal) t = svpwm_pkg::OneVal;
      return t[15:0];
   endfunction

   // Working format equals Q15 here, so inputs need no rescaling.
   function automatic duty_type predict_duties(longint d, longint q, longint s, longint c);
      longint one = svpwm_pkg::OneVal;
      longint m, r, rc, al, be, ka, hb, u1, u2, u3, x, y, t7, ta, tb, tc, sm;
      logic [2:0] sec;
      duty_type res;
      m = d * d + q * q;
      if (m > (longint'(1) << 30)) begin
         r = sqrt_floor(m);
         rc = (longint'(1) << 30) / r;
         d = floor_shift(d * rc, 15);
         q = floor_shift(q * rc, 15);
      end
      al = floor_shift(d * c - q * s, 15);
      be = floor_shift(q * c + d * s, 15);
      ka = floor_shift(longint'(svpwm_pkg::KCoef) * al, 15);
      hb = floor_shift(be, 1);
      u1 = be;
      u2 = -ka - hb;
      u3 = ka - hb;
      sec = {u3 > 0, u2 > 0, u1 > 0};
      case (sec)
         3'd5: begin x = u3; y = u1; end
         3'd1: begin x = -u3; y = -u2; end
         3'd3: begin x = u1; y = u2; end
         3'd2: begin x = -u1; y = -u3; end
         3'd6: begin x = u2; y = u3; end
         3'd4: begin x = -u2; y = -u1; end
         default: begin x = 0; y = 0; end
      endcase
      sm = x + y;
      if (sm > one) begin
         x = (x * one) / sm;
         y = (y * one) / sm;
      end
      t7 = floor_shift(one - x - y, 1);
      case (sec)
         3'd5: begin ta = x + y + t7; tb = y + t7; tc = t7; end
         3'd1: begin ta = y + t7; tb = x + y + t7; tc = t7; end
         3'd3: begin ta = t7; tb = x + y + t7; tc = y + t7; end
         3'd2: begin ta = t7; tb = y + t7; tc = x + y + t7; end
         3'd6: begin ta = y + t7; tb = t7; tc = x + y + t7; end
         3'd4: begin ta = x + y + t7; tb = t7; tc = y + t7; end
         default: begin ta = one >> 1; tb = one >> 1; tc = one >> 1; end
      endcase
      res.duty_u = clamp_q15(ta);
      res.duty_v = clamp_q15(tb);
      res.duty_w = clamp_q15(tc);
      res.sector = sec;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      duty_type want;
      if (!reset && rsp_valid) begin
         if (expected_duties.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            error_count++;
         end else begin
            want = expected_duties.pop_front();
            if (rsp_duty_u !== want.duty_u) report_mismatch("duty_u", rsp_duty_u, want.duty_u);
            if (rsp_duty_v !== want.duty_v) report_mismatch("duty_v", rsp_duty_v, want.duty_v);
            if (rsp_duty_w !== want.duty_w) report_mismatch("duty_w", rsp_duty_w, want.duty_w);
            if (rsp_sector_code !== want.sector)
               report_mismatch("sector", 16'(rsp_sector_code), 16'(want.sector));
         end
      end
   end

   // Start stays high across back-to-back items; it drops only for idle gaps.
   task automatic send_item(logic [15:0] d, logic [15:0] q, logic [15:0] s, logic [15:0] c);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_d_voltage <= d;
      req_q_voltage <= q;
      req_angle_sine <= s;
      req_angle_cosine <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_duties.push_back(predict_duties(longint'($signed(d)), longint'($signed(q)),
                                               longint'($signed(s)), longint'($signed(c))));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_duties.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(2000)) - 16'd1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] ext[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h0001};
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);  // zero vector
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // full negative
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);  // limiting, non-unit angle
      send_item(16'h8000, 16'h7FFF, 16'h0000, 16'h8000);
      for (int i = 0; i < 6; i++)
         send_item(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6], ext[(i + 1) % 6]);
      // One command rotated through all six sectors.
      for (int a = 0; a < 12; a++) begin
         real th = a * 3.14159265 / 6.0 + 0.1;
         send_item(16'h0000, 16'h5000, 16'($rtoi(32767.0 * $sin(th))),
                   16'($rtoi(32767.0 * $cos(th))));
      end
      wait_drained();
   endtask

   task automatic test_random(int count, int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            send_item(pick_value(), pick_value(), pick_value(), pick_value());
         end else begin
            // Unit-circle angle with a random command.
            real th = $urandom_range(62831) / 10000.0;
            send_item(16'($urandom), 16'($urandom_range(40000) - 20000),
                      16'($rtoi(32767.0 * $sin(th))), 16'($rtoi(32767.0 * $cos(th))));
         end
      end
      wait_drained();
      idle_pct = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(500, 0);
      test_random(400, 83);
      test_random(300, 20);
      test_random(400, 0);
      repeat (100) @(negedge clock);
      if (error_count == 0 && expected_duties.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/svpwm_pkg.sv
rtl/svpwm_divider.sv
rtl/svpwm_duty_generator.sv
test/tb_top.sv
